// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the arrive steering integrator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASI_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASI_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/asi_pkg.sv -----
// ----------------------------------------------------------------------------
// asi_pkg
// types, register codes, reset values and saturation helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asi_pkg;

  localparam int unsigned FracBits = 16;

  localparam logic [30:0] MaxSpeedRst  = 31'((64'd2 << FracBits) & 64'h7FFF_FFFF);
  localparam logic [30:0] MaxForceRst  =
    31'((((64'd1 << FracBits) + 64'd5) / 64'd10) & 64'h7FFF_FFFF);
  localparam logic [30:0] SlowRadRst   = 31'((64'd50 << FracBits) & 64'h7FFF_FFFF);
  localparam logic [30:0] BodyMassRst  = 31'((64'd5 << FracBits) & 64'h7FFF_FFFF);
  localparam logic signed [31:0] OneFix = 32'(64'd1 << FracBits);

  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_MAX_FORCE   = 2'd1,
    REG_SLOW_RADIUS = 2'd2,
    REG_BODY_MASS   = 2'd3
  } asi_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_LSQ, ST_LCMP,
    ST_ROOT, ST_ROOTW, ST_RMUL, ST_RDIV, ST_RDIVW,
    ST_SCX, ST_DVX, ST_DVXW, ST_SCY, ST_DVY, ST_DVYW,
    ST_SUB, ST_ADDV, ST_FIN, ST_OUT
  } asi_state_e;

  typedef enum logic [1:0] {
    PH_ARR, PH_LIMF, PH_ACC, PH_LIMV
  } asi_phase_e;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } asi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } asi_out_t;

  function automatic logic signed [31:0] sat_sum(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? SatMin : SatMax;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_quot(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (!neg) begin
      r = (|mag[63:31]) ? SatMax : {1'b0, mag[30:0]};
    end else if ((|mag[63:32]) || (mag[31] && (|mag[30:0]))) begin
      r = SatMin;
    end else begin
      r = ~mag[31:0] + 32'd1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/arrive_steering_integrator.sv -----
// ----------------------------------------------------------------------------
// arrive_steering_integrator
// 2-D point agent steering toward a target with the arrive rule
// ----------------------------------------------------------------------------
// One word in, one word out. A place word goes straight to the result. The
// shared one-bit-a-cycle divider does two to nine divides per steer word,
// each with its multiply and handshake; the shared root unit does one to
// three roots. One 32x32 multiplier feeds both units. Input stall stays high
// from acceptance until the result word has been taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arrive_steering_integrator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  asi_pkg::asi_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output asi_pkg::asi_out_t out_word_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [30:0]       cfg_data_i
);

  asi_pkg::asi_state_e state_q, state_d;
  asi_pkg::asi_phase_e phase_q, phase_d;

  logic [30:0] max_speed_q, max_force_q, slow_q, mass_q;

  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [31:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic signed [31:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic signed [31:0] wx_q, wx_d, wy_q, wy_d;
  logic [63:0]        acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic [31:0]        len_q, len_d;
  logic [30:0]        m_q, m_d;
  asi_pkg::asi_out_t  out_q, out_d;

  logic               mul_en;
  logic signed [31:0] mul_a, mul_b, k_sel;
  logic [31:0]        den_sel;
  logic [30:0]        lim_sel;
  logic [63:0]        prod_mag;

  logic        div_start, div_busy, div_done;
  logic [63:0] div_dvd, div_q;
  logic [31:0] div_dvs;
  logic        sqrt_start, sqrt_busy, sqrt_done;
  logic [31:0] sqrt_root;

  asi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  asi_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_q),
    .busy_o     (sqrt_busy),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= asi_pkg::MaxSpeedRst;
      max_force_q <= asi_pkg::MaxForceRst;
      slow_q      <= asi_pkg::SlowRadRst;
      mass_q      <= asi_pkg::BodyMassRst;
    end else if (cfg_we_i) begin
      unique case (asi_pkg::asi_reg_e'(cfg_idx_i))
        asi_pkg::REG_MAX_SPEED:   max_speed_q <= cfg_data_i;
        asi_pkg::REG_MAX_FORCE:   max_force_q <= cfg_data_i;
        asi_pkg::REG_SLOW_RADIUS: slow_q      <= cfg_data_i;
        asi_pkg::REG_BODY_MASS:   mass_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // gain and divisor of the scaling pass, the limit of the length test and the product magnitude
  always_comb begin
    unique case (phase_q)
      asi_pkg::PH_ARR: begin
        k_sel   = {1'b0, m_q};
        den_sel = len_q;
      end
      asi_pkg::PH_LIMF: begin
        k_sel   = {1'b0, max_force_q};
        den_sel = len_q;
      end
      asi_pkg::PH_ACC: begin
        k_sel   = asi_pkg::OneFix;
        den_sel = (mass_q == '0) ? 32'd1 : {1'b0, mass_q};
      end
      default: begin
        k_sel   = {1'b0, max_speed_q};
        den_sel = len_q;
      end
    endcase
    lim_sel  = (phase_q == asi_pkg::PH_LIMF) ? max_force_q : max_speed_q;
    prod_mag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    vel_x_d    = vel_x_q;
    vel_y_d    = vel_y_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    wx_d       = wx_q;
    wy_d       = wy_q;
    acc_d      = acc_q;
    len_d      = len_q;
    m_d        = m_q;
    out_d      = out_q;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = prod_mag;
    div_dvs    = den_sel;
    sqrt_start = 1'b0;

    unique case (state_q)
      asi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.mode) begin
            pos_x_d = in_word_i.target_x;
            pos_y_d = in_word_i.target_y;
            vel_x_d = '0;
            vel_y_d = '0;
            out_d   = '{pos_x: in_word_i.target_x, pos_y: in_word_i.target_y,
                        vel_x: '0, vel_y: '0};
            state_d = asi_pkg::ST_OUT;
          end else begin
            tgt_x_d = in_word_i.target_x;
            tgt_y_d = in_word_i.target_y;
            state_d = asi_pkg::ST_DIFF;
          end
        end
      end
      asi_pkg::ST_DIFF: begin
        wx_d    = asi_pkg::sat_sum(33'(tgt_x_q) - 33'(pos_x_q));
        wy_d    = asi_pkg::sat_sum(33'(tgt_y_q) - 33'(pos_y_q));
        phase_d = asi_pkg::PH_ARR;
        state_d = asi_pkg::ST_SQX;
      end
      asi_pkg::ST_SQX: begin
        mul_en  = 1'b1;
        mul_a   = wx_q;
        mul_b   = wx_q;
        state_d = asi_pkg::ST_SQY;
      end
      asi_pkg::ST_SQY: begin
        acc_d   = $unsigned(prod_q);
        mul_en  = 1'b1;
        mul_a   = wy_q;
        mul_b   = wy_q;
        state_d = asi_pkg::ST_SUM;
      end
      asi_pkg::ST_SUM: begin
        acc_d   = acc_q + $unsigned(prod_q);
        state_d = (phase_q == asi_pkg::PH_ARR) ? asi_pkg::ST_ROOT : asi_pkg::ST_LSQ;
      end
      asi_pkg::ST_LSQ: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, lim_sel};
        mul_b   = {1'b0, lim_sel};
        state_d = asi_pkg::ST_LCMP;
      end
      asi_pkg::ST_LCMP: begin
        if (acc_q > {prod_q[62:0], 1'b0}) begin
          state_d = asi_pkg::ST_ROOT;
        end else if (phase_q == asi_pkg::PH_LIMF) begin
          phase_d = asi_pkg::PH_ACC;
          state_d = asi_pkg::ST_SCX;
        end else begin
          state_d = asi_pkg::ST_FIN;
        end
      end
      asi_pkg::ST_ROOT: begin
        sqrt_start = 1'b1;
        state_d    = asi_pkg::ST_ROOTW;
      end
      asi_pkg::ST_ROOTW: begin
        if (sqrt_done) begin
          len_d = sqrt_root;
          if (phase_q != asi_pkg::PH_ARR) begin
            state_d = asi_pkg::ST_SCX;
          end else if (sqrt_root == '0) begin
            // zero offset, desired velocity stays zero
            state_d = asi_pkg::ST_SUB;
          end else if (sqrt_root < {1'b0, slow_q}) begin
            state_d = asi_pkg::ST_RMUL;
          end else begin
            m_d     = max_speed_q;
            state_d = asi_pkg::ST_SCX;
          end
        end
      end
      asi_pkg::ST_RMUL: begin
        mul_en  = 1'b1;
        mul_a   = $signed(len_q);
        mul_b   = {1'b0, max_speed_q};
        state_d = asi_pkg::ST_RDIV;
      end
      asi_pkg::ST_RDIV: begin
        div_start = 1'b1;
        div_dvs   = {1'b0, slow_q};
        state_d   = asi_pkg::ST_RDIVW;
      end
      asi_pkg::ST_RDIVW: begin
        if (div_done) begin
          m_d     = div_q[30:0];
          state_d = (len_q == '0) ? asi_pkg::ST_SUB : asi_pkg::ST_SCX;
        end
      end
      asi_pkg::ST_SCX: begin
        mul_en  = 1'b1;
        mul_a   = wx_q;
        mul_b   = k_sel;
        state_d = asi_pkg::ST_DVX;
      end
      asi_pkg::ST_DVX: begin
        div_start = 1'b1;
        state_d   = asi_pkg::ST_DVXW;
      end
      asi_pkg::ST_DVXW: begin
        if (div_done) begin
          wx_d    = asi_pkg::sat_quot(prod_q[63], div_q);
          state_d = asi_pkg::ST_SCY;
        end
      end
      asi_pkg::ST_SCY: begin
        mul_en  = 1'b1;
        mul_a   = wy_q;
        mul_b   = k_sel;
        state_d = asi_pkg::ST_DVY;
      end
      asi_pkg::ST_DVY: begin
        div_start = 1'b1;
        state_d   = asi_pkg::ST_DVYW;
      end
      asi_pkg::ST_DVYW: begin
        if (div_done) begin
          wy_d = asi_pkg::sat_quot(prod_q[63], div_q);
          unique case (phase_q)
            asi_pkg::PH_ARR:  state_d = asi_pkg::ST_SUB;
            asi_pkg::PH_LIMF: begin
              phase_d = asi_pkg::PH_ACC;
              state_d = asi_pkg::ST_SCX;
            end
            asi_pkg::PH_ACC:  state_d = asi_pkg::ST_ADDV;
            default:          state_d = asi_pkg::ST_FIN;
          endcase
        end
      end
      asi_pkg::ST_SUB: begin
        wx_d    = asi_pkg::sat_sum(33'(wx_q) - 33'(vel_x_q));
        wy_d    = asi_pkg::sat_sum(33'(wy_q) - 33'(vel_y_q));
        phase_d = asi_pkg::PH_LIMF;
        state_d = asi_pkg::ST_SQX;
      end
      asi_pkg::ST_ADDV: begin
        wx_d    = asi_pkg::sat_sum(33'(vel_x_q) + 33'(wx_q));
        wy_d    = asi_pkg::sat_sum(33'(vel_y_q) + 33'(wy_q));
        phase_d = asi_pkg::PH_LIMV;
        state_d = asi_pkg::ST_SQX;
      end
      asi_pkg::ST_FIN: begin
        vel_x_d = wx_q;
        vel_y_d = wy_q;
        pos_x_d = asi_pkg::sat_sum(33'(pos_x_q) + 33'(wx_q));
        pos_y_d = asi_pkg::sat_sum(33'(pos_y_q) + 33'(wy_q));
        out_d   = '{pos_x: pos_x_d, pos_y: pos_y_d, vel_x: wx_q, vel_y: wy_q};
        state_d = asi_pkg::ST_OUT;
      end
      asi_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = asi_pkg::ST_IDLE;
        end
      end
      default: state_d = asi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asi_pkg::ST_IDLE;
      phase_q <= asi_pkg::PH_ARR;
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_x_q <= tgt_x_d;
    tgt_y_q <= tgt_y_d;
    wx_q    <= wx_d;
    wy_q    <= wy_d;
    acc_q   <= acc_d;
    len_q   <= len_d;
    m_q     <= m_d;
    out_q   <= out_d;
    if (mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign in_stall_o  = (state_q != asi_pkg::ST_IDLE);
  assign out_valid_o = (state_q == asi_pkg::ST_OUT);
  assign out_word_o  = out_q;

  `ASI_ASSERT_NEXT(a_accept_then_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "word accepted while block not busy next cycle")
  `ASI_ASSERT(a_units_exclusive, clk_i, rst_ni, $onehot0({div_busy, sqrt_busy}), "divider and root unit busy together")
  `ASI_ASSERT(a_start_when_free, clk_i, rst_ni, !(div_start && div_busy) && !(sqrt_start && sqrt_busy), "unit restarted while busy")

endmodule

// ----- rtl/asi_div.sv -----
// ----------------------------------------------------------------------------
// asi_div
// restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d, dvs_q;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    trial = {rem_q, quo_q[63]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
    quo_d = {quo_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/asi_isqrt.sv -----
// ----------------------------------------------------------------------------
// asi_isqrt
// floor square root of a 64-bit value, two radicand bits a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asi_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [35:0] cur, trial;
  logic        ge;

  always_comb begin
    cur    = {rem_q, rad_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = cur >= trial;
    rem_d  = ge ? 34'(cur - trial) : cur[33:0];
    root_d = {root_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- tb/arrive_steering_integrator_tb.sv -----
// ----------------------------------------------------------------------------
// arrive_steering_integrator_tb
// self-checking bench for the arrive steering integrator
// ----------------------------------------------------------------------------
// A short table of place and steer words runs first. Where a row's result is
// obvious it is typed in; every other row is checked against a predictor that
// keeps its own copy of the agent state and the registers. Random phases
// follow, each under new register values (defaults, extremes, zeros,
// moderate). The phases vary the pattern of sender gaps and receiver stalls,
// and two run with neither. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arrive_steering_integrator_tb;

  localparam int NumPlan  = 12;
  localparam int PerPhase = 388;

  typedef struct {
    logic               mode;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    bit                 typed;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  asi_pkg::asi_in_t   in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  asi_pkg::asi_out_t  out_word_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = asi_pkg::REG_MAX_SPEED;
  logic [30:0]        cfg_data_i = '0;

  asi_pkg::asi_out_t expected_words[$];
  int                errors = 0;
  int                sender_idle_pct = 0;
  int                recv_stall_pct = 0;

  longint          agent_px, agent_py, agent_vx, agent_vy;
  longint unsigned lim_speed, lim_force, ramp_radius, mass_fix;

  plan_row_t plan[NumPlan] = '{
    '{1'b0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b1, asi_pkg::SatMax, asi_pkg::SatMax, 1'b1, asi_pkg::SatMax, asi_pkg::SatMax,
      32'sd0, 32'sd0},
    '{1'b0, asi_pkg::SatMax, asi_pkg::SatMax, 1'b1, asi_pkg::SatMax, asi_pkg::SatMax,
      32'sd0, 32'sd0},
    '{1'b0, asi_pkg::SatMin, asi_pkg::SatMin, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b1, asi_pkg::SatMin, asi_pkg::SatMin, 1'b1, asi_pkg::SatMin, asi_pkg::SatMin,
      32'sd0, 32'sd0},
    '{1'b0, asi_pkg::SatMax, asi_pkg::SatMin, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b1, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, 32'sh000A_0000, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, 32'sh0064_0000, 32'sh0064_0000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, -32'sh0005_0000, 32'sh0003_0000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b1, 32'sh1234_5678, 32'shEDCB_A987, 1'b1, 32'sh1234_5678, 32'shEDCB_A987,
      32'sd0, 32'sd0},
    '{1'b0, 32'sh1234_5679, 32'shEDCB_0000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
  };

  arrive_steering_integrator DUT (.*);

  always #2 clk_i = ~clk_i;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned square_len(input longint x, input longint y);
    return longint'(x * x) + longint'(y * y);
  endfunction

  function automatic void cap_vector(inout longint x, inout longint y,
                                     input longint unsigned lim);
    longint unsigned sq;
    longint len;
    sq = square_len(x, y);
    if (sq > 2 * lim * lim) begin
      len = longint'(floor_root(sq));
      x = (x * longint'(lim)) / len;
      y = (y * longint'(lim)) / len;
    end
  endfunction

  // one control tick of the agent
  function automatic asi_pkg::asi_out_t advance_agent(input asi_pkg::asi_in_t w);
    longint tx, ty, ex, ey, dx, dy, sx, sy, vx, vy, mass;
    longint unsigned len, m;
    asi_pkg::asi_out_t r;
    tx = longint'(w.target_x);
    ty = longint'(w.target_y);
    if (w.mode) begin
      agent_px = tx;
      agent_py = ty;
      agent_vx = 0;
      agent_vy = 0;
    end else begin
      ex = clamp32(tx - agent_px);
      ey = clamp32(ty - agent_py);
      len = floor_root(square_len(ex, ey));
      m = lim_speed;
      dx = 0;
      dy = 0;
      mass = (mass_fix == 0) ? 64'sd1 : longint'(mass_fix);
      if (len < ramp_radius) m = (len * lim_speed) / ramp_radius;
      if (len != 0) begin
        dx = (ex * longint'(m)) / longint'(len);
        dy = (ey * longint'(m)) / longint'(len);
      end
      sx = clamp32(dx - agent_vx);
      sy = clamp32(dy - agent_vy);
      cap_vector(sx, sy, lim_force);
      vx = clamp32(agent_vx + clamp32((sx * (64'sd1 << asi_pkg::FracBits)) / mass));
      vy = clamp32(agent_vy + clamp32((sy * (64'sd1 << asi_pkg::FracBits)) / mass));
      cap_vector(vx, vy, lim_speed);
      agent_vx = vx;
      agent_vy = vy;
      agent_px = clamp32(agent_px + agent_vx);
      agent_py = clamp32(agent_py + agent_vy);
    end
    r.pos_x = 32'(agent_px);
    r.pos_y = 32'(agent_py);
    r.vel_x = 32'(agent_vx);
    r.vel_y = 32'(agent_vy);
    return r;
  endfunction

  // drives one word and waits for it to be taken
  task automatic send_word(input asi_pkg::asi_in_t w, output asi_pkg::asi_out_t pred);
    if (sender_idle_pct > 0) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    in_word_i = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = advance_agent(w);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input asi_pkg::asi_reg_e idx, input logic [30:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      asi_pkg::REG_MAX_SPEED:   lim_speed = 64'(val);
      asi_pkg::REG_MAX_FORCE:   lim_force = 64'(val);
      asi_pkg::REG_SLOW_RADIUS: ramp_radius = 64'(val);
      default:                  mass_fix = 64'(val);
    endcase
  endtask

  task automatic drain_block();
    in_valid_i = 1'b0;
    wait (expected_words.size() == 0);
    repeat (8) @(negedge clk_i);
  endtask

  // receiver: stall at the falling edge, check at the rising edge
  initial begin
    asi_pkg::asi_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", out_word_o);
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (out_word_o.pos_x !== want.pos_x || out_word_o.pos_y !== want.pos_y ||
              out_word_o.vel_x !== want.vel_x || out_word_o.vel_y !== want.vel_y) begin
            errors++;
            if (errors <= 10)
              $display("mismatch pos %0d,%0d vel %0d,%0d expected pos %0d,%0d vel %0d,%0d",
                       out_word_o.pos_x, out_word_o.pos_y, out_word_o.vel_x,
                       out_word_o.vel_y, want.pos_x, want.pos_y, want.vel_x, want.vel_y);
          end
        end
      end
      @(negedge clk_i);
      out_stall_i = (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    asi_pkg::asi_in_t  w;
    asi_pkg::asi_out_t pred;
    int                pick;
    lim_speed = 64'(asi_pkg::MaxSpeedRst);
    lim_force = 64'(asi_pkg::MaxForceRst);
    ramp_radius = 64'(asi_pkg::SlowRadRst);
    mass_fix = 64'(asi_pkg::BodyMassRst);
    agent_px = 0;
    agent_py = 0;
    agent_vx = 0;
    agent_vy = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      w = '{mode: plan[i].mode, target_x: plan[i].tx, target_y: plan[i].ty};
      send_word(w, pred);
      if (plan[i].typed) begin
        pred = '{pos_x: plan[i].px, pos_y: plan[i].py, vel_x: plan[i].vx,
                 vel_y: plan[i].vy};
      end
      expected_words.push_back(pred);
    end

    for (int ph = 0; ph < 5; ph++) begin
      drain_block();
      case (ph)
        1: begin
          write_reg(asi_pkg::REG_MAX_SPEED, 31'h7FFF_FFFF);
          write_reg(asi_pkg::REG_MAX_FORCE, 31'h7FFF_FFFF);
          write_reg(asi_pkg::REG_SLOW_RADIUS, 31'd1);
          write_reg(asi_pkg::REG_BODY_MASS, 31'd65536);
          sender_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(asi_pkg::REG_MAX_SPEED, '0);
          write_reg(asi_pkg::REG_MAX_FORCE, '0);
          write_reg(asi_pkg::REG_SLOW_RADIUS, '0);
          write_reg(asi_pkg::REG_BODY_MASS, '0);
          sender_idle_pct = 0;
          recv_stall_pct = 74;
        end
        3, 4: begin
          write_reg(asi_pkg::REG_MAX_SPEED,
                    31'($urandom_range(32'h0000_1000, 32'h0010_0000)));
          write_reg(asi_pkg::REG_MAX_FORCE,
                    31'($urandom_range(32'h0000_0100, 32'h0004_0000)));
          write_reg(asi_pkg::REG_SLOW_RADIUS,
                    31'($urandom_range(32'h0001_0000, 32'h0100_0000)));
          write_reg(asi_pkg::REG_BODY_MASS,
                    31'($urandom_range(32'h0000_8000, 32'h0010_0000)));
          sender_idle_pct = (ph == 3) ? 15 : 0;
          recv_stall_pct = (ph == 3) ? 15 : 0;
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < PerPhase; n++) begin
        if (ph == 4 && n == PerPhase / 2) drain_block();
        pick = $urandom_range(9);
        w.mode = (pick == 0);
        if (pick <= 1) begin
          w.target_x = $urandom;
          w.target_y = $urandom;
        end else begin
          // near the agent so the slow ramp and small steers get exercised
          w.target_x = 32'(clamp32(agent_px + longint'(int'($urandom_range(0, 32'h0040_0000)))
                                   - 64'sh20_0000));
          w.target_y = 32'(clamp32(agent_py + longint'(int'($urandom_range(0, 32'h0040_0000)))
                                   - 64'sh20_0000));
        end
        send_word(w, pred);
        expected_words.push_back(pred);
      end
    end

    in_valid_i = 1'b0;
    wait (expected_words.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
